// ----- src/qfe_pkg.sv -----
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared types and constants of the quadratic form evaluator.
// ----------------------------------------------------------------------------
package qfe_pkg;

  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int MADDR_W  = 2 * IDX_W;
  localparam int CNT_W    = $clog2(MAX_SIZE + 2);
  localparam int SIZE_W   = 5;
  localparam int CMP_W    = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
  localparam int DATA_W   = 32;
  localparam int MUL_W    = 2 * DATA_W;
  localparam int PROD_W   = MUL_W + DATA_W;
  localparam int ACC_W    = PROD_W + 2 * IDX_W + 1;
  localparam int RES_W    = 64;
  localparam int LIN_SH   = 17;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  localparam logic [1:0] OP_MATRIX  = 2'd0;
  localparam logic [1:0] OP_LINEAR  = 2'd1;
  localparam logic [1:0] OP_ELEMENT = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } qfe_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic                    size_error;
  } qfe_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFETCH,
    ST_ROW,
    ST_LIN,
    ST_DRAIN,
    ST_EMIT
  } qfe_state_t;

  typedef enum logic [1:0] {
    K_XI,
    K_MAC,
    K_LIN
  } qfe_kind_t;

  typedef struct packed {
    logic      valid;
    qfe_kind_t kind;
  } qfe_ctl_t;

endpackage

// ----- src/quadratic_form_evaluator.sv -----
// Loads, unused ops and non-final vector elements are accepted only while idle.
// A final element of a correctly sized vector starts an evaluation of active
// size n: one matrix read and multiply-accumulate per cycle, one extra slot per
// row for the linear term, then a pipeline drain. A size error goes straight to
// the result. A result held by a low out_ready delays the next evaluation.
// Reset (rst_n low, synchronous) clears control state and sets active size 16.
// ----------------------------------------------------------------------------
// quadratic_form_evaluator
// Evaluates 0.5*x'Ax + b'x in Q16.16 with a saturated Q32.32 result.
// ----------------------------------------------------------------------------
module quadratic_form_evaluator
  import qfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qfe_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qfe_out_t          out_data,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data
);

  qfe_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] size_r;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  qfe_out_t          out_data_r, out_data_nxt;
  qfe_ctl_t          ctl_r, ctl_nxt;

  logic              accept;
  logic              start;
  logic [CNT_W-1:0]  cnt_inc;
  logic              size_bad;
  logic [SIZE_W-1:0] size_m1;
  logic [IDX_W-1:0]  last_idx;

  logic               mat_we, lin_we, vec_we;
  logic [MADDR_W-1:0] mat_raddr;
  logic [IDX_W-1:0]   lin_raddr, vec_raddr;
  logic [DATA_W-1:0]  mat_rdata, lin_rdata, vec_rdata;
  logic               mac_busy;
  logic signed [RES_W-1:0] mac_result;

  assign accept   = in_valid & in_ready;
  assign size_m1  = size_r - SIZE_W'(1);
  assign last_idx = IDX_W'(size_m1);
  assign cnt_inc  = (cnt_r <= CNT_W'(MAX_SIZE)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign size_bad = (size_r == '0) || (CMP_W'(size_r) > CMP_W'(MAX_SIZE)) ||
                    (CMP_W'(cnt_inc) != CMP_W'(size_r));

  assign mat_we = accept && (in_data.op == OP_MATRIX);
  assign lin_we = accept && (in_data.op == OP_LINEAR);
  assign vec_we = accept && (in_data.op == OP_ELEMENT) && (cnt_r < CNT_W'(MAX_SIZE));

  qfe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr ({in_data.row[IDX_W-1:0], in_data.col[IDX_W-1:0]}),
    .wdata (in_data.value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  qfe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_lin_ram (
    .clk   (clk),
    .we    (lin_we),
    .waddr (in_data.row[IDX_W-1:0]),
    .wdata (in_data.value),
    .raddr (lin_raddr),
    .rdata (lin_rdata)
  );

  qfe_ram #(.WIDTH(DATA_W), .DEPTH(MAX_SIZE)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (in_data.value),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  qfe_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (start),
    .ctl      (ctl_r),
    .vec_data ($signed(vec_rdata)),
    .mat_data ($signed(mat_rdata)),
    .lin_data ($signed(lin_rdata)),
    .busy     (mac_busy),
    .result   (mac_result)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    ctl_nxt       = '{valid: 1'b0, kind: K_XI};
    in_ready      = 1'b0;
    start         = 1'b0;
    mat_raddr     = {i_r, j_r};
    lin_raddr     = i_r;
    vec_raddr     = j_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && (in_data.op == OP_ELEMENT)) begin
          cnt_nxt = cnt_inc;
          if (in_data.last) begin
            cnt_nxt = '0;
            err_nxt = size_bad;
            i_nxt   = '0;
            j_nxt   = '0;
            if (size_bad) begin
              state_nxt = ST_EMIT;
            end else begin
              start     = 1'b1;
              state_nxt = ST_PREFETCH;
            end
          end
        end
      end
      ST_PREFETCH: begin
        vec_raddr = i_r;
        ctl_nxt   = '{valid: 1'b1, kind: K_XI};
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        ctl_nxt = '{valid: 1'b1, kind: K_MAC};
        if (j_r == last_idx) begin
          state_nxt = ST_LIN;
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      ST_LIN: begin
        vec_raddr = i_r + IDX_W'(1);
        ctl_nxt   = '{valid: 1'b1, kind: K_LIN};
        j_nxt     = '0;
        if (i_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_ROW;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_data_nxt = '{result: '0, size_error: 1'b1};
          end else begin
            out_data_nxt = '{result: mac_result, size_error: 1'b0};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
      size_r      <= SIZE_RESET;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ctl_r       <= '{valid: 1'b0, kind: K_XI};
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      ctl_r       <= ctl_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SIZE + 1))
    else $error("element count beyond saturation");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.size_error) |-> (out_data.result == '0))
    else $error("size error with non-zero result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_busy)
    else $error("pipeline active while idle");

  a_last_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == OP_ELEMENT) && in_data.last) |=>
      ((state_r == ST_PREFETCH) || (state_r == ST_EMIT)))
    else $error("final element did not start evaluation");
`endif

endmodule

// ----- src/qfe_ram.sv -----
// ----------------------------------------------------------------------------
// qfe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/qfe_mac.sv -----
// ----------------------------------------------------------------------------
// qfe_mac
// Multiply-accumulate pipeline: x(i)*x(j), split product with the matrix or
// linear entry, wide accumulation and the final scale and saturation.
// ----------------------------------------------------------------------------
module qfe_mac
  import qfe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  qfe_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] vec_data,
  input  logic signed [DATA_W-1:0] mat_data,
  input  logic signed [DATA_W-1:0] lin_data,
  output logic                     busy,
  output logic signed [RES_W-1:0]  result
);

  logic signed [DATA_W-1:0] xi_r, xi_nxt;
  logic signed [MUL_W-1:0]  m_r, m_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic                     v2_r, v2_nxt;
  logic signed [MUL_W:0]    plo_r;
  logic signed [MUL_W-1:0]  phi_r;
  logic                     v3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     v4_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [MUL_W-1:0]  xx;
  logic signed [ACC_W-1:0]  scaled;
  logic                     in_range;

  assign xx = MUL_W'(xi_r) * MUL_W'(vec_data);

  always_comb begin
    xi_nxt = xi_r;
    m_nxt  = m_r;
    a_nxt  = a_r;
    v2_nxt = 1'b0;
    if (ctl.valid) begin
      unique case (ctl.kind)
        K_XI: begin
          xi_nxt = vec_data;
        end
        K_MAC: begin
          m_nxt  = xx;
          a_nxt  = mat_data;
          v2_nxt = 1'b1;
        end
        K_LIN: begin
          m_nxt  = MUL_W'(xi_r) <<< LIN_SH;
          a_nxt  = lin_data;
          v2_nxt = 1'b1;
          xi_nxt = vec_data;
        end
        default: begin
          v2_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    xi_r   <= xi_nxt;
    m_r    <= m_nxt;
    a_r    <= a_nxt;
    plo_r  <= (MUL_W+1)'($signed({1'b0, m_r[DATA_W-1:0]})) * (MUL_W+1)'(a_r);
    phi_r  <= MUL_W'($signed(m_r[MUL_W-1:DATA_W])) * MUL_W'(a_r);
    prod_r <= $signed({phi_r, {DATA_W{1'b0}}}) + PROD_W'(plo_r);
    if (clear) begin
      acc_r <= '0;
    end else if (v4_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign busy     = ctl.valid | v2_r | v3_r | v4_r;
  assign scaled   = acc_r >>> LIN_SH;
  assign in_range = (&scaled[ACC_W-1:RES_W-1]) | ~(|scaled[ACC_W-1:RES_W-1]);

  always_comb begin
    if (in_range) begin
      result = scaled[RES_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      result = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

endmodule
